>>> hw/rtl/nns_pkg.sv
// Package for the nearest-neighbour image scaler.
// Payload structs, register indexes, sequencer states and fixed field widths.
// No dependencies.
package nns_pkg;

  localparam int unsigned COORD_W    = 12;
  localparam int unsigned PIX_W      = 32;
  localparam int unsigned SCALE_W    = 24;
  localparam int unsigned DIM_CFG_W  = 9;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned PROD_W     = COORD_W + SCALE_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [DIM_CFG_W-1:0] DIM_RESET   = 9'd256;
  localparam logic [SCALE_W-1:0]   SCALE_RESET = 24'd65536;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_REQ  = 1'b1
  } nns_func_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_ROWS = 2'd0,
    CFG_SOURCE_COLS = 2'd1,
    CFG_INV_SCALE_X = 2'd2,
    CFG_INV_SCALE_Y = 2'd3
  } nns_cfg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_Y,
    ST_MUL_X,
    ST_FIT_X,
    ST_READ
  } nns_state_e;

  typedef struct packed {
    logic               func;
    logic [COORD_W-1:0] row_index;
    logic [COORD_W-1:0] col_index;
    logic [PIX_W-1:0]   pixel_in;
  } nns_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             edge_clamped;
  } nns_out_t;

endpackage

>>> hw/rtl/nns_map.sv
// Shared coordinate mapping unit: one registered 12x24 multiply and an edge clamp.
// Depends on nns_pkg.
module nns_map #(
  parameter int unsigned IDX_W = 8,
  parameter int unsigned DIM_W = 9
) (
  input  logic                        clk_i,
  input  logic                        mul_en_i,
  input  logic [nns_pkg::COORD_W-1:0] coord_i,
  input  logic [nns_pkg::SCALE_W-1:0] inv_i,
  input  logic [DIM_W-1:0]            dim_i,
  output logic [IDX_W-1:0]            fit_o,
  output logic                        clamp_o
);
  import nns_pkg::*;

  localparam int unsigned SRC_W = PROD_W - FRAC_W;

  logic [PROD_W-1:0] prod_q;
  logic [SRC_W-1:0]  src;
  logic [DIM_W-1:0]  dim_m1;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= PROD_W'(coord_i) * PROD_W'(inv_i);
    end
  end

  // fraction dropped, then clamp to the last row/column
  assign src     = prod_q[PROD_W-1:FRAC_W];
  assign dim_m1  = dim_i - DIM_W'(1);
  assign clamp_o = (src >= SRC_W'(dim_i));
  assign fit_o   = clamp_o ? dim_m1[IDX_W-1:0] : src[IDX_W-1:0];

endmodule

>>> hw/rtl/nns_store.sv
// Frame store: one write port, one registered read port.
// Depends on nns_pkg.
module nns_store #(
  parameter int unsigned ADDR_W = 16
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [ADDR_W-1:0]         waddr_i,
  input  logic [nns_pkg::PIX_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [ADDR_W-1:0]         raddr_i,
  output logic [nns_pkg::PIX_W-1:0] rdata_o
);
  import nns_pkg::*;

  localparam int unsigned DEPTH = 2 ** ADDR_W;

  logic [PIX_W-1:0] mem [DEPTH];
  logic [PIX_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/nearest_neighbour_image_scaler.sv
// Nearest-neighbour image scaler. A load (func 0) is taken when start is high and busy is low
// and writes the frame store; busy stays low. A request (func 1) is taken under the same
// condition, and its result appears with out_valid_o for one cycle in ST_READ, after ST_MUL_Y,
// ST_MUL_X and ST_FIT_X; the receiver cannot stall, so it must take it then. A new item may be
// started in that result cycle. A request passes through one shared 12x24 multiplier used in
// turn for the row and the column (each product registered, then clamped to the image edge) and
// the single registered read port of the store. The store holds 2^ROW_W * 2^COL_W words
// (ROW_W, COL_W = ceil(log2) of MAX_ROWS, MAX_COLS, at least 1); there is no clearing pass.
// Depends on nns_pkg, nns_map and nns_store.
module nearest_neighbour_image_scaler #(
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_COLS = 256
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  nns_pkg::nns_in_t               in_i,
  output logic                           out_valid_o,
  output nns_pkg::nns_out_t              out_o,
  input  logic                           cfg_we_i,
  input  logic [nns_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [nns_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import nns_pkg::*;

  localparam int unsigned ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned IDX_W   = (ROW_W > COL_W) ? ROW_W : COL_W;
  localparam int unsigned MAX_DIM = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int unsigned DIM_W   = $clog2(MAX_DIM + 1);
  localparam int unsigned CMP_W   = (DIM_W > DIM_CFG_W) ? DIM_W : DIM_CFG_W;
  localparam int unsigned LIM_W   = COORD_W + 1;

  nns_state_e state_q, state_d;

  logic [DIM_CFG_W-1:0] source_rows_q, source_cols_q;
  logic [SCALE_W-1:0]   inv_scale_x_q, inv_scale_y_q;

  logic [COORD_W-1:0] row_q, col_q;
  logic [ROW_W-1:0]   sy_q;
  logic               clamp_q;

  logic               accept, accept_req, load_we;
  logic               mul_en, rd_en;
  logic [COORD_W-1:0] mul_coord;
  logic [SCALE_W-1:0] mul_inv;
  logic [DIM_W-1:0]   fit_dim;
  logic [IDX_W-1:0]   fit;
  logic               fit_clamp;
  logic [DIM_W-1:0]   rows_lim, cols_lim;
  logic [CMP_W-1:0]   rows_ext, cols_ext;
  logic [PIX_W-1:0]   rdata;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      source_rows_q <= DIM_RESET;
      source_cols_q <= DIM_RESET;
      inv_scale_x_q <= SCALE_RESET;
      inv_scale_y_q <= SCALE_RESET;
    end else if (cfg_we_i) begin
      unique case (nns_cfg_e'(cfg_idx_i))
        CFG_SOURCE_ROWS: source_rows_q <= cfg_data_i[DIM_CFG_W-1:0];
        CFG_SOURCE_COLS: source_cols_q <= cfg_data_i[DIM_CFG_W-1:0];
        CFG_INV_SCALE_X: inv_scale_x_q <= cfg_data_i;
        CFG_INV_SCALE_Y: inv_scale_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize acts as the store limit
  assign rows_ext = CMP_W'(source_rows_q);
  assign cols_ext = CMP_W'(source_cols_q);

  always_comb begin
    if (source_rows_q == '0) begin
      rows_lim = DIM_W'(1);
    end else if (rows_ext > CMP_W'(MAX_ROWS)) begin
      rows_lim = DIM_W'(MAX_ROWS);
    end else begin
      rows_lim = rows_ext[DIM_W-1:0];
    end
    if (source_cols_q == '0) begin
      cols_lim = DIM_W'(1);
    end else if (cols_ext > CMP_W'(MAX_COLS)) begin
      cols_lim = DIM_W'(MAX_COLS);
    end else begin
      cols_lim = cols_ext[DIM_W-1:0];
    end
  end

  assign accept     = start && !busy;
  assign accept_req = accept && (nns_func_e'(in_i.func) == FUNC_REQ);
  assign load_we    = accept && (nns_func_e'(in_i.func) == FUNC_LOAD)
                      && (LIM_W'(in_i.row_index) < LIM_W'(MAX_ROWS))
                      && (LIM_W'(in_i.col_index) < LIM_W'(MAX_COLS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    busy        = 1'b1;
    out_valid_o = 1'b0;
    mul_en      = 1'b0;
    rd_en       = 1'b0;
    mul_coord   = row_q;
    mul_inv     = inv_scale_y_q;
    fit_dim     = rows_lim;
    unique case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (accept_req) begin
          state_d = ST_MUL_Y;
        end
      end
      ST_MUL_Y: begin
        mul_en  = 1'b1;
        state_d = ST_MUL_X;
      end
      ST_MUL_X: begin
        // row product fitted while the column product is formed
        mul_en    = 1'b1;
        mul_coord = col_q;
        mul_inv   = inv_scale_x_q;
        state_d   = ST_FIT_X;
      end
      ST_FIT_X: begin
        fit_dim = cols_lim;
        rd_en   = 1'b1;
        state_d = ST_READ;
      end
      ST_READ: begin
        busy        = 1'b0;
        out_valid_o = 1'b1;
        state_d     = accept_req ? ST_MUL_Y : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept_req) begin
      row_q <= in_i.row_index;
      col_q <= in_i.col_index;
    end
    if (state_q == ST_MUL_X) begin
      sy_q    <= fit[ROW_W-1:0];
      clamp_q <= fit_clamp;
    end else if (state_q == ST_FIT_X) begin
      clamp_q <= clamp_q | fit_clamp;
    end
  end

  nns_map #(
    .IDX_W (IDX_W),
    .DIM_W (DIM_W)
  ) u_map (
    .clk_i    (clk_i),
    .mul_en_i (mul_en),
    .coord_i  (mul_coord),
    .inv_i    (mul_inv),
    .dim_i    (fit_dim),
    .fit_o    (fit),
    .clamp_o  (fit_clamp)
  );

  nns_store #(
    .ADDR_W (ROW_W + COL_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i ({in_i.row_index[ROW_W-1:0], in_i.col_index[COL_W-1:0]}),
    .wdata_i (in_i.pixel_in),
    .re_i    (rd_en),
    .raddr_i ({sy_q, fit[COL_W-1:0]}),
    .rdata_o (rdata)
  );

  assign out_o.pixel_out    = rdata;
  assign out_o.edge_clamped = clamp_q;

  a_req_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_req |-> ##4 out_valid_o)
    else $error("request transfer without result four cycles later");

  a_req_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_req |=> busy)
    else $error("busy not raised after request transfer");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !accept_req) |=> !out_valid_o)
    else $error("load produced a result");

  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |=> !out_valid_o)
    else $error("result strobe longer than one cycle");

  a_valid_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !busy && !mul_en)
    else $error("result shown while mapping unit active");

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for nearest_neighbour_image_scaler: pixel loads and scaled-pixel
// requests under several register settings, checked against an in-bench pixel predictor.
// Depends on nns_pkg and the scaler RTL.
module tb_top;
  import nns_pkg::*;

  localparam int unsigned ROWS_MAX        = 256;
  localparam int unsigned COLS_MAX        = 256;
  localparam int unsigned STALL_LIMIT     = 1000;
  localparam int unsigned ITEMS_PER_PHASE = 140;
  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned COORD_TOP       = 4095;

  // Predicts scaled pixels from its own copy of the frame store and the registers.
  class scaler_scoreboard;
    logic [PIX_W-1:0]     frame [ROWS_MAX*COLS_MAX];
    bit                   loaded [ROWS_MAX*COLS_MAX];
    logic [DIM_CFG_W-1:0] rows_reg;
    logic [DIM_CFG_W-1:0] cols_reg;
    logic [SCALE_W-1:0]   inv_x;
    logic [SCALE_W-1:0]   inv_y;
    nns_out_t             pending_px [$];
    int unsigned          mismatches;
    int unsigned          n_loads;
    int unsigned          n_reqs;
    int unsigned          n_clamped;
    int unsigned          n_results;

    function new();
      rows_reg   = DIM_RESET;
      cols_reg   = DIM_RESET;
      inv_x      = SCALE_RESET;
      inv_y      = SCALE_RESET;
      mismatches = 0;
      n_loads    = 0;
      n_reqs     = 0;
      n_clamped  = 0;
      n_results  = 0;
    endfunction

    function void write_reg(nns_cfg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SOURCE_ROWS: rows_reg = data[DIM_CFG_W-1:0];
        CFG_SOURCE_COLS: cols_reg = data[DIM_CFG_W-1:0];
        CFG_INV_SCALE_X: inv_x = data[SCALE_W-1:0];
        CFG_INV_SCALE_Y: inv_y = data[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // zero acts as one, anything past the store acts as the store size
    function int unsigned eff_dim(logic [DIM_CFG_W-1:0] v, int unsigned lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    function int unsigned fit_coord(logic [COORD_W-1:0] c, logic [SCALE_W-1:0] inv,
                                    int unsigned dim, inout bit clamped);
      logic [PROD_W-1:0]        prod;
      logic [PROD_W-FRAC_W-1:0] src;
      prod = PROD_W'(c) * PROD_W'(inv);
      src  = prod[PROD_W-1:FRAC_W];
      if (src >= dim) begin
        clamped = 1'b1;
        return dim - 1;
      end
      return src;
    endfunction

    function int unsigned source_addr(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                                      output bit clamped);
      int unsigned sy;
      int unsigned sx;
      clamped = 1'b0;
      sy = fit_coord(row, inv_y, eff_dim(rows_reg, ROWS_MAX), clamped);
      sx = fit_coord(col, inv_x, eff_dim(cols_reg, COLS_MAX), clamped);
      return sy * COLS_MAX + sx;
    endfunction

    function void note_transfer(nns_in_t item);
      int unsigned addr;
      bit          clamped;
      nns_out_t    want;
      if (item.func == FUNC_LOAD) begin
        if (item.row_index < ROWS_MAX && item.col_index < COLS_MAX) begin
          addr         = item.row_index * COLS_MAX + item.col_index;
          frame[addr]  = item.pixel_in;
          loaded[addr] = 1'b1;
          n_loads++;
        end
      end else begin
        addr              = source_addr(item.row_index, item.col_index, clamped);
        want.pixel_out    = frame[addr];
        want.edge_clamped = clamped;
        pending_px.push_back(want);
        n_reqs++;
        if (clamped) n_clamped++;
      end
    endfunction

    function void check_result(nns_out_t got);
      nns_out_t want;
      if (pending_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: pixel %08h clamp %0b", got.pixel_out, got.edge_clamped);
        return;
      end
      want = pending_px.pop_front();
      n_results++;
      if (got.pixel_out !== want.pixel_out || got.edge_clamped !== want.edge_clamped) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch at %0t: expected pixel %08h clamp %0b, got pixel %08h clamp %0b",
                   $realtime, want.pixel_out, want.edge_clamped, got.pixel_out,
                   got.edge_clamped);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  nns_in_t               in_i;
  logic                  out_valid_o;
  nns_out_t              out_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  scaler_scoreboard sb = new();
  int unsigned      idle_cycles = 0;
  int unsigned      n_settings = 0;
  int unsigned      n_sent = 0;
  bit               burst = 1'b0;
  int unsigned      burst_left = 0;

  nearest_neighbour_image_scaler #(
    .MAX_ROWS(ROWS_MAX),
    .MAX_COLS(COLS_MAX)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_o      (out_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) sb.check_result(out_o);
  end

  // ends the run when neither side has moved a transfer for too long
  always @(posedge clk_i) begin
    if ((start && !busy) || out_valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
               idle_cycles, sb.pending_px.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // runs of back-to-back items and runs of random gaps, each kind picked at random per run
  function automatic int unsigned next_gap();
    if (burst_left == 0) begin
      burst      = ($urandom_range(0, 3) == 0);
      burst_left = $urandom_range(10, 60);
    end
    burst_left--;
    return burst ? 0 : $urandom_range(0, 9);
  endfunction

  task automatic send_item(nns_in_t item);
    int unsigned gap;
    gap = next_gap();
    repeat (gap) begin
      @(negedge clk_i);
      start <= 1'b0;
    end
    @(negedge clk_i);
    start <= 1'b1;
    in_i  <= item;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_transfer(item);
    n_sent++;
  endtask

  task automatic load_pixel(int unsigned row, int unsigned col, logic [PIX_W-1:0] pix);
    nns_in_t item;
    item.func      = FUNC_LOAD;
    item.row_index = COORD_W'(row);
    item.col_index = COORD_W'(col);
    item.pixel_in  = pix;
    send_item(item);
  endtask

  // a request always lands on a written entry: load it first where needed
  task automatic ask_pixel(int unsigned row, int unsigned col);
    nns_in_t     item;
    int unsigned addr;
    bit          clamped;
    addr = sb.source_addr(COORD_W'(row), COORD_W'(col), clamped);
    if (!sb.loaded[addr]) load_pixel(addr / COLS_MAX, addr % COLS_MAX, $urandom);
    item.func      = FUNC_REQ;
    item.row_index = COORD_W'(row);
    item.col_index = COORD_W'(col);
    item.pixel_in  = $urandom;
    send_item(item);
  endtask

  task automatic wait_all_results();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending_px.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(nns_cfg_e idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // upper data bits on the dimension registers are junk the block must drop
  task automatic set_scaling(int unsigned rows, int unsigned cols,
                             int unsigned ix, int unsigned iy);
    write_reg(CFG_SOURCE_ROWS, {15'($urandom), DIM_CFG_W'(rows)});
    write_reg(CFG_SOURCE_COLS, {15'($urandom), DIM_CFG_W'(cols)});
    write_reg(CFG_INV_SCALE_X, SCALE_W'(ix));
    write_reg(CFG_INV_SCALE_Y, SCALE_W'(iy));
    n_settings++;
  endtask

  // at or just past the first output coordinate that maps outside the image, capped at COORD_TOP
  function automatic int unsigned reach(logic [SCALE_W-1:0] inv, int unsigned dim);
    int unsigned r;
    if (inv == 0) return COORD_TOP;
    r = ((dim << FRAC_W) / inv) + 1;
    return (r > COORD_TOP) ? COORD_TOP : r;
  endfunction

  task automatic random_items(int unsigned count);
    int unsigned first;
    int unsigned pick;
    int unsigned row;
    int unsigned col;
    int unsigned rows_eff;
    int unsigned cols_eff;
    first = n_sent;
    while (n_sent < first + count) begin
      rows_eff = sb.eff_dim(sb.rows_reg, ROWS_MAX);
      cols_eff = sb.eff_dim(sb.cols_reg, COLS_MAX);
      pick     = $urandom_range(0, 99);
      if (pick < 12) begin
        // noise over the whole coordinate range, mostly outside the store
        row = $urandom_range(0, COORD_TOP);
        col = $urandom_range(0, COORD_TOP);
        load_pixel(row, col, $urandom);
      end else if (pick < 40) begin
        load_pixel($urandom_range(0, rows_eff - 1), $urandom_range(0, cols_eff - 1),
                   $urandom);
      end else begin
        row = (pick < 52) ? $urandom_range(0, COORD_TOP)
                          : $urandom_range(0, reach(sb.inv_y, rows_eff));
        col = (pick > 88) ? $urandom_range(0, COORD_TOP)
                          : $urandom_range(0, reach(sb.inv_x, cols_eff));
        ask_pixel(row, col);
      end
      if ($urandom_range(0, 79) == 0) wait_all_results();
    end
  endtask

  task automatic directed_items();
    load_pixel(0, 0, 32'hFFFF_FFFF);
    load_pixel(ROWS_MAX - 1, COLS_MAX - 1, 32'h0000_0000);
    load_pixel(ROWS_MAX - 1, 0, 32'hA5A5_A5A5);
    load_pixel(0, COLS_MAX - 1, 32'h5A5A_5A5A);
    // loads outside the store are dropped
    load_pixel(COORD_TOP, COORD_TOP, 32'h1234_5678);
    load_pixel(ROWS_MAX, 3, 32'hDEAD_BEEF);
    load_pixel(3, COLS_MAX, 32'hCAFE_F00D);
    ask_pixel(0, 0);
    ask_pixel(ROWS_MAX - 1, COLS_MAX - 1);
    ask_pixel(COORD_TOP, COORD_TOP);
    ask_pixel(0, COORD_TOP);
    ask_pixel(COORD_TOP, 0);
    ask_pixel(ROWS_MAX, COLS_MAX - 1);
    load_pixel(0, 0, 32'h8000_0001);
    ask_pixel(0, 0);
    wait_all_results();
  endtask

  initial begin
    int unsigned failures;
    rst_ni     = 1'b0;
    start      = 1'b0;
    in_i       = '0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_SOURCE_ROWS;
    cfg_data_i = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: directed_items();
        1: set_scaling(0, 511, 0, 24'hFF_FFFF);
        2: set_scaling(1, 1, 1, 1);
        3: set_scaling(ROWS_MAX, COLS_MAX, 24'h00_8000, 24'h02_0000);
        4: set_scaling($urandom_range(1, 256), $urandom_range(1, 256),
                       $urandom_range(24'h00_2000, 24'h03_0000),
                       $urandom_range(24'h00_2000, 24'h03_0000));
        5: set_scaling(511, 0, 24'hFF_FFFF, 0);
        6: set_scaling($urandom_range(0, 511), $urandom_range(0, 511),
                       $urandom_range(0, 24'hFF_FFFF), $urandom_range(0, 24'hFF_FFFF));
        default: set_scaling($urandom_range(1, 256), $urandom_range(1, 256),
                             $urandom_range(24'h00_4000, 24'h01_4000),
                             $urandom_range(24'h00_4000, 24'h01_4000));
      endcase
      random_items(ITEMS_PER_PHASE);
      wait_all_results();
    end

    failures = sb.mismatches + sb.pending_px.size();
    $display("run covered %0d items: %0d stored loads and %0d requests (%0d edge-clamped)",
             n_sent, sb.n_loads, sb.n_reqs, sb.n_clamped);
    $display("over %0d settings; %0d results checked, %0d failures", n_settings + 1,
             sb.n_results, failures);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
